FILE: hdl/dms_pkg.sv
`default_nettype none

package dms_pkg;

  localparam int CMD_W   = 3;
  localparam int SPEED_W = 10;
  localparam int DIST_W  = 24;
  localparam int ANGLE_W = 16;
  localparam int HEAD_W  = 16;
  localparam int ODO_W   = 32;
  localparam int DRIVE_W = 12;
  localparam int GAIN_W  = 10;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd100;

  localparam logic [CMD_W-1:0] CMD_STRAIGHT_DIST  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STRAIGHT_TRIG  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STRAIGHT_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PIVOT_ABS      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PIVOT_DELTA    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PIVOT_TRIG     = 3'd5;

  localparam logic signed [15:0] DEG16_TO_Q12 = 16'sd18301;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
  } dms_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/dms_ctrl.sv
`default_nettype none

module dms_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dms_pkg::dms_cmd_t    ctl
);
  import dms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    ctl.load   = (state_r == ST_IDLE) && in_valid;
    ctl.mul1   = (state_r == ST_MUL1);
    ctl.mul2   = (state_r == ST_MUL2);
    ctl.commit = (state_r == ST_FIN) && !(out_valid_r && out_stall);

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (ctl.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/dms_dp.sv
`default_nettype none

module dms_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire dms_pkg::dms_cmd_t                     ctl,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [dms_pkg::GAIN_W-1:0]     cfg_wr_data,
  input  wire logic        [dms_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic        [dms_pkg::SPEED_W-1:0]    in_speed,
  input  wire logic signed [dms_pkg::DIST_W-1:0]     in_target_distance,
  input  wire logic signed [dms_pkg::ANGLE_W-1:0]    in_target_angle,
  input  wire logic                                  in_direction,
  input  wire logic                                  in_stop_request,
  input  wire logic signed [dms_pkg::HEAD_W-1:0]     in_heading_now,
  input  wire logic signed [dms_pkg::ODO_W-1:0]      in_odometer,
  output logic signed      [dms_pkg::DRIVE_W-1:0]    out_left_drive,
  output logic signed      [dms_pkg::DRIVE_W-1:0]    out_right_drive,
  output logic                                       out_task_done
);
  import dms_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_EXEC,
    PH_END
  } phase_t;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [20:0] v);
    logic signed [DRIVE_W-1:0] res;
    if (v > 21'sd2047) begin
      res = 12'sd2047;
    end else if (v < -21'sd2047) begin
      res = -12'sd2047;
    end else begin
      res = v[DRIVE_W-1:0];
    end
    return res;
  endfunction

  // Captured input item.
  logic        [CMD_W-1:0]   cmd_r;
  logic        [SPEED_W-1:0] speed_r;
  logic signed [DIST_W-1:0]  tdist_r;
  logic signed [ANGLE_W-1:0] tang_r;
  logic                      dir_r;
  logic                      stop_r;
  logic signed [HEAD_W-1:0]  hnow_r;
  logic signed [ODO_W-1:0]   odo_r;

  // Pipeline registers.
  logic signed [18:0]        tq_r;
  logic        [ODO_W:0]     dist_abs_r;
  logic        [DIST_W-1:0]  tdist_abs_r;
  logic signed [30:0]        prod2_r;

  // Mode state.
  logic        [GAIN_W-1:0]  gain_r;
  phase_t                    phase_r [6];
  phase_t                    phase_nxt [6];
  logic        [2:0]         ssign_r, ssign_nxt;
  logic        [2:0]         psign_r, psign_nxt;
  logic signed [HEAD_W-1:0]  held_r [2];
  logic signed [HEAD_W-1:0]  held_nxt [2];
  logic signed [ODO_W-1:0]   sdist_r, sdist_nxt;
  logic signed [HEAD_W-1:0]  shead_r, shead_nxt;

  logic signed [DRIVE_W-1:0] left_r, right_r, left_nxt, right_nxt;
  logic                      done_r, done_nxt;

  // First multiply and distance span.
  logic signed [31:0]        prod1;
  logic signed [ODO_W:0]     odo_diff;

  assign prod1    = 32'(tang_r) * 32'(DEG16_TO_Q12);
  assign odo_diff = {odo_r[ODO_W-1], odo_r} - {sdist_r[ODO_W-1], sdist_r};

  // Second multiply: heading error times gain.
  logic signed [18:0]        ref_head;
  logic signed [19:0]        err;
  logic signed [GAIN_W:0]    gain_s;

  assign ref_head = (cmd_r == CMD_STRAIGHT_HEAD) ? tq_r : 19'(held_r[cmd_r[0]]);
  assign err      = 20'(ref_head) - 20'(hnow_r);
  assign gain_s   = {1'b0, gain_r};

  // Final step.
  logic signed [31:0]        rsum;
  logic signed [19:0]        corr;
  logic signed [20:0]        spd_s;
  logic signed [20:0]        sum_l, sum_r;
  logic signed [DRIVE_W-1:0] sat_l, sat_r, spd12;
  logic signed [19:0]        pdiff;
  logic signed [16:0]        moved;
  logic        [1:0]         pidx;
  logic                      neg;
  logic                      fin;

  assign rsum  = {prod2_r[30], prod2_r} + (prod2_r[30] ? 32'sd2047 : 32'sd2048);
  assign corr  = rsum[31:12];
  assign spd_s = {11'b0, speed_r};
  assign sum_l = spd_s + 21'(corr);
  assign sum_r = spd_s - 21'(corr);
  assign sat_l = sat_drive(sum_l);
  assign sat_r = sat_drive(sum_r);
  assign spd12 = {2'b0, speed_r};
  assign pdiff = 20'(tq_r) - 20'(hnow_r);
  assign moved = 17'(hnow_r) - 17'(shead_r);
  assign pidx  = 2'(cmd_r - CMD_PIVOT_ABS);

  always_comb begin
    phase_nxt = phase_r;
    ssign_nxt = ssign_r;
    psign_nxt = psign_r;
    held_nxt  = held_r;
    sdist_nxt = sdist_r;
    shead_nxt = shead_r;
    left_nxt  = '0;
    right_nxt = '0;
    done_nxt  = 1'b0;
    neg       = 1'b0;
    fin       = 1'b0;

    if (cmd_r <= CMD_PIVOT_TRIG) begin
      case (phase_r[cmd_r])
        PH_EXEC: begin
          if (cmd_r <= CMD_STRAIGHT_HEAD) begin
            neg       = ssign_r[cmd_r[1:0]];
            left_nxt  = neg ? -sat_l : sat_l;
            right_nxt = neg ? -sat_r : sat_r;
            if (cmd_r == CMD_STRAIGHT_DIST) begin
              fin = (dist_abs_r >= {{(ODO_W + 1 - DIST_W){1'b0}}, tdist_abs_r});
            end else begin
              fin = stop_r;
            end
          end else begin
            neg       = psign_r[pidx];
            left_nxt  = neg ? -spd12 : spd12;
            right_nxt = neg ? spd12 : -spd12;
            if (cmd_r == CMD_PIVOT_ABS) begin
              fin = neg ? (pdiff >= 20'sd0) : (pdiff <= 20'sd0);
            end else if (cmd_r == CMD_PIVOT_DELTA) begin
              fin = neg ? (19'(moved) <= tq_r) : (19'(moved) >= tq_r);
            end else begin
              fin = stop_r;
            end
          end
          phase_nxt[cmd_r] = fin ? PH_END : PH_EXEC;
        end
        PH_END: begin
          done_nxt         = 1'b1;
          phase_nxt[cmd_r] = PH_INIT;
        end
        default: begin
          case (cmd_r)
            CMD_STRAIGHT_DIST: begin
              sdist_nxt    = odo_r;
              held_nxt[0]  = hnow_r;
              ssign_nxt[0] = tdist_r[DIST_W-1];
            end
            CMD_STRAIGHT_TRIG: begin
              held_nxt[1]  = hnow_r;
              ssign_nxt[1] = dir_r;
            end
            CMD_STRAIGHT_HEAD: ssign_nxt[2] = dir_r;
            CMD_PIVOT_ABS:     psign_nxt[0] = !(pdiff > 20'sd0);
            CMD_PIVOT_DELTA: begin
              psign_nxt[1] = !(tang_r > 16'sd0);
              shead_nxt    = hnow_r;
            end
            default:           psign_nxt[2] = !dir_r;
          endcase
          phase_nxt[cmd_r] = PH_EXEC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      speed_r <= in_speed;
      tdist_r <= in_target_distance;
      tang_r  <= in_target_angle;
      dir_r   <= in_direction;
      stop_r  <= in_stop_request;
      hnow_r  <= in_heading_now;
      odo_r   <= in_odometer;
    end
    if (ctl.mul1) begin
      tq_r        <= prod1[30:12];
      dist_abs_r  <= odo_diff[ODO_W] ? 33'(-odo_diff) : 33'(odo_diff);
      tdist_abs_r <= tdist_r[DIST_W-1] ? DIST_W'(-tdist_r) : DIST_W'(tdist_r);
    end
    if (ctl.mul2) begin
      prod2_r <= 31'(gain_s) * 31'(err);
    end
    if (ctl.commit) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      phase_r <= '{default: PH_INIT};
      ssign_r <= '0;
      psign_r <= '0;
      held_r  <= '{default: '0};
      sdist_r <= '0;
      shead_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (ctl.commit) begin
        phase_r <= phase_nxt;
        ssign_r <= ssign_nxt;
        psign_r <= psign_nxt;
        held_r  <= held_nxt;
        sdist_r <= sdist_nxt;
        shead_r <= shead_nxt;
      end
    end
  end

  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_task_done   = done_r;

endmodule

`default_nettype wire

FILE: hdl/drive_motion_sequencer.sv
// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// input    | in_valid, in_stall, in_cmd .. in_odometer         | in
// result   | out_valid, out_stall, out_left_drive .. task_done | out
// config   | cfg_wr_en, cfg_wr_data (heading gain)             | in
//
// An item passes from transfer to result through capture, the angle
// conversion multiply, the heading-gain multiply, then drive and mode update.
// One item is in work at a time.
// Synchronous reset puts every mode in its Init phase and the gain at 100.
// A stalled result holds in the output register; the next item may be taken
// meanwhile and waits in its last step until the result register frees.
`default_nettype none

module drive_motion_sequencer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [dms_pkg::GAIN_W-1:0]     cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [dms_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic        [dms_pkg::SPEED_W-1:0]    in_speed,
  input  wire logic signed [dms_pkg::DIST_W-1:0]     in_target_distance,
  input  wire logic signed [dms_pkg::ANGLE_W-1:0]    in_target_angle,
  input  wire logic                                  in_direction,
  input  wire logic                                  in_stop_request,
  input  wire logic signed [dms_pkg::HEAD_W-1:0]     in_heading_now,
  input  wire logic signed [dms_pkg::ODO_W-1:0]      in_odometer,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [dms_pkg::DRIVE_W-1:0]    out_left_drive,
  output logic signed      [dms_pkg::DRIVE_W-1:0]    out_right_drive,
  output logic                                       out_task_done
);
  import dms_pkg::*;

  dms_cmd_t ctl;

  dms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  dms_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_cmd             (in_cmd),
    .in_speed           (in_speed),
    .in_target_distance (in_target_distance),
    .in_target_angle    (in_target_angle),
    .in_direction       (in_direction),
    .in_stop_request    (in_stop_request),
    .in_heading_now     (in_heading_now),
    .in_odometer        (in_odometer),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_task_done      (out_task_done)
  );

endmodule

`default_nettype wire
